>>> rtl/uerf_pkg.sv
// ----------------------------------------------------------------------------
// uerf_pkg
// Shared widths, reset values, register codes and lane interface structs for
// the ultrasonic echo ranging filter.
// ----------------------------------------------------------------------------
package uerf_pkg;

    // default sizes handed to the top level
    localparam int WINDOW_DEF   = 10;
    localparam int CHANNELS_DEF = 3;

    // field widths
    localparam int TICK_W   = 16;
    localparam int DIST_W   = 21;
    localparam int RATE_W   = 25;
    localparam int DELTA_W  = 22;
    localparam int SCALE_W  = 24;
    localparam int COUNT_W  = 8;
    localparam int CHAN_W   = 2;
    localparam int CFG_W    = 24;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 64;
    localparam int FRAC_SH  = 16;

    // number of echo lines that carry a real level
    localparam int LINES    = 3;

    // reset values and limits
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd115159;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd3;
    localparam int                 SUM_BIAS    = 100;
    localparam logic [DIST_W-1:0]  DIST_MAX    = 21'd2097151;

    // configuration register codes
    typedef enum logic [0:0] {
        REG_DIST_SCALE = 1'b0,
        REG_MEAS_LIMIT = 1'b1
    } cfg_reg_t;

    // pipeline control from the top level to every lane
    typedef struct packed {
        logic load1;   // event word accepted with a completion
        logic adv1;    // stage 1 moves into stage 2
        logic adv2;    // stage 2 moves into the output bundle
    } lane_ctl_t;

    // finished measurement presented by a lane at stage 2
    typedef struct packed {
        logic                     done;
        logic [TICK_W-1:0]        width;
        logic [DIST_W-1:0]        dist_q8;
        logic signed [RATE_W-1:0] rate;
    } lane_res_t;

endpackage

>>> rtl/uerf_lane.sv
// ----------------------------------------------------------------------------
// uerf_lane
// One echo channel: edge detection and pulse timing, pulse window sum,
// distance multiply, saturation and moving sum of distance changes.
// ----------------------------------------------------------------------------
module uerf_lane
    import uerf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctl_t         ctl,
    input  logic              acc,
    input  logic              level,
    input  logic [TICK_W-1:0] now,
    input  logic [SCALE_W-1:0] scale,
    output logic              done,
    output lane_res_t         res
);

    localparam int POS_W  = $clog2(WINDOW);
    localparam int SUM_W  = $clog2(WINDOW * 65535 + SUM_BIAS + 1);
    localparam int PROD_W = SUM_W + SCALE_W;
    localparam int DR_W   = PROD_W - FRAC_SH;

    // edge detection and pulse timing
    logic              seen_reg;
    logic [TICK_W-1:0] start_reg;
    logic              rise;
    logic              fall;
    logic [TICK_W-1:0] width_s0;

    assign rise     = level & ~seen_reg;
    assign fall     = ~level & seen_reg;
    assign width_s0 = now - start_reg;
    assign done     = fall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 1'b0;
            start_reg <= '0;
        end
        else if (acc)
        begin
            seen_reg <= level;
            if (rise)
            begin
                start_reg <= now;
            end
        end
    end

    // pulse window ring and running sum
    logic [TICK_W-1:0] pring_mem [WINDOW];
    logic [TICK_W-1:0] prd_reg;
    logic [TICK_W-1:0] prd_eff;
    logic [POS_W-1:0]  ppos_reg;
    logic [POS_W-1:0]  ppos_next;
    logic [POS_W-1:0]  ppos_rd;
    logic              pfill_reg;
    logic [SUM_W-1:0]  psum_reg;
    logic [SUM_W-1:0]  psum_next;
    logic              pwr;

    assign pwr       = acc & fall;
    assign ppos_next = (ppos_reg == POS_W'(WINDOW - 1)) ? '0 : ppos_reg + 1'b1;
    assign ppos_rd   = pwr ? ppos_next : ppos_reg;
    assign prd_eff   = pfill_reg ? prd_reg : '0;
    assign psum_next = psum_reg - SUM_W'(prd_eff) + SUM_W'(width_s0);

    always_ff @(posedge clk)
    begin
        if (pwr)
        begin
            pring_mem[ppos_reg] <= width_s0;
        end
        prd_reg <= pring_mem[ppos_rd];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppos_reg  <= '0;
            pfill_reg <= 1'b0;
            psum_reg  <= SUM_W'(SUM_BIAS);
        end
        else if (pwr)
        begin
            ppos_reg <= ppos_next;
            psum_reg <= psum_next;
            if (ppos_reg == POS_W'(WINDOW - 1))
            begin
                pfill_reg <= 1'b1;
            end
        end
    end

    // stage 1: pulse sum held for the multiply
    logic              done1_reg;
    logic [TICK_W-1:0] width1_reg;
    logic [SUM_W-1:0]  sum1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done1_reg <= 1'b0;
        end
        else if (ctl.load1)
        begin
            done1_reg <= fall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load1)
        begin
            width1_reg <= width_s0;
            sum1_reg   <= psum_next;
        end
    end

    // stage 2: registered product of sum and scale
    logic              done2_reg;
    logic [TICK_W-1:0] width2_reg;
    logic [PROD_W-1:0] prod2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done2_reg <= 1'b0;
        end
        else if (ctl.adv1)
        begin
            done2_reg <= done1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv1)
        begin
            width2_reg <= width1_reg;
            prod2_reg  <= PROD_W'(sum1_reg) * PROD_W'(scale);
        end
    end

    // distance saturation and change window
    logic [DR_W-1:0]          d_raw;
    logic [DIST_W-1:0]        dist_sat;
    logic [DIST_W-1:0]        prev_reg;
    logic signed [DELTA_W-1:0] delta;
    logic signed [DELTA_W-1:0] cring_mem [WINDOW];
    logic signed [DELTA_W-1:0] crd_reg;
    logic signed [DELTA_W-1:0] crd_eff;
    logic [POS_W-1:0]         cpos_reg;
    logic [POS_W-1:0]         cpos_next;
    logic [POS_W-1:0]         cpos_rd;
    logic                     cfill_reg;
    logic signed [RATE_W-1:0] csum_reg;
    logic signed [RATE_W-1:0] csum_next;
    logic                     cwr;

    assign d_raw    = prod2_reg[PROD_W-1:FRAC_SH];
    assign dist_sat = (d_raw > {{(DR_W - DIST_W){1'b0}}, DIST_MAX}) ?
                      DIST_MAX : d_raw[DIST_W-1:0];
    assign delta    = $signed({1'b0, dist_sat}) - $signed({1'b0, prev_reg});

    assign cwr       = ctl.adv2 & done2_reg;
    assign cpos_next = (cpos_reg == POS_W'(WINDOW - 1)) ? '0 : cpos_reg + 1'b1;
    assign cpos_rd   = cwr ? cpos_next : cpos_reg;
    assign crd_eff   = cfill_reg ? crd_reg : '0;
    assign csum_next = csum_reg
                     - {{(RATE_W - DELTA_W){crd_eff[DELTA_W-1]}}, crd_eff}
                     + {{(RATE_W - DELTA_W){delta[DELTA_W-1]}}, delta};

    always_ff @(posedge clk)
    begin
        if (cwr)
        begin
            cring_mem[cpos_reg] <= delta;
        end
        crd_reg <= cring_mem[cpos_rd];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpos_reg  <= '0;
            cfill_reg <= 1'b0;
            csum_reg  <= '0;
            prev_reg  <= '0;
        end
        else if (cwr)
        begin
            cpos_reg <= cpos_next;
            csum_reg <= csum_next;
            prev_reg <= dist_sat;
            if (cpos_reg == POS_W'(WINDOW - 1))
            begin
                cfill_reg <= 1'b1;
            end
        end
    end

    // result towards the merge stage
    assign res.done    = done2_reg;
    assign res.width   = width2_reg;
    assign res.dist_q8 = dist_sat;
    assign res.rate    = csum_next;

endmodule

>>> rtl/uerf_merge.sv
// ----------------------------------------------------------------------------
// uerf_merge
// Collects the lane results of one event into a bundle register and sends
// them out one word per cycle while m_tready is high, lowest channel first.
// ----------------------------------------------------------------------------
module uerf_merge
    import uerf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              trig_in,
    input  lane_res_t         res [CHANNELS],
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // channel, pulse_ticks, distance_q8, rate_q8
    output logic [0:0]        m_tuser,   // trigger
    output logic              m_tlast
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                     bvalid_reg;
    logic                     trig_reg;
    logic [CHANNELS-1:0]      mask_reg;
    logic [TICK_W-1:0]        width_reg [CHANNELS];
    logic [DIST_W-1:0]        dist_reg  [CHANNELS];
    logic signed [RATE_W-1:0] rate_reg  [CHANNELS];

    logic [CHANNELS-1:0] sel_oh;
    logic [CHANNELS-1:0] remain;
    logic [CH_W-1:0]     sel_idx;
    logic [7:0]          chan_wide;
    logic                take;
    logic                is_last;

    // lowest pending channel
    assign sel_oh  = mask_reg & (~mask_reg + 1'b1);
    assign remain  = mask_reg & ~sel_oh;
    assign is_last = (remain == '0);
    assign take    = bvalid_reg & m_tready;
    assign free    = ~bvalid_reg | (m_tready & is_last);

    always_comb
    begin
        sel_idx = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (sel_oh[c])
            begin
                sel_idx = sel_idx | CH_W'(c);
            end
        end
    end

    // bundle control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvalid_reg <= 1'b0;
            mask_reg   <= '0;
            trig_reg   <= 1'b0;
        end
        else if (load)
        begin
            bvalid_reg <= 1'b1;
            trig_reg   <= trig_in;
            for (int c = 0; c < CHANNELS; c++)
            begin
                mask_reg[c] <= res[c].done;
            end
        end
        else if (take)
        begin
            mask_reg <= remain;
            if (is_last)
            begin
                bvalid_reg <= 1'b0;
            end
        end
    end

    // bundle payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                width_reg[c] <= res[c].width;
                dist_reg[c]  <= res[c].dist_q8;
                rate_reg[c]  <= res[c].rate;
            end
        end
    end

    // output word
    assign chan_wide  = 8'(sel_idx);
    assign m_tvalid   = bvalid_reg;
    assign m_tlast    = is_last;
    assign m_tuser[0] = trig_reg & is_last;
    assign m_tdata    = {rate_reg[sel_idx], dist_reg[sel_idx], width_reg[sel_idx],
                         chan_wide[CHAN_W-1:0]};

    // checks
    a_bundle_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        bvalid_reg |-> (mask_reg != '0))
        else $error("bundle valid with no pending channel");

    a_one_select: assert property (@(posedge clk) disable iff (!rst_n)
        bvalid_reg |-> $onehot(sel_oh))
        else $error("channel select not one-hot");

    a_trigger_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("trigger on a word that is not last");

    a_word_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !is_last && !load) |=> (bvalid_reg && $countones(mask_reg) ==
            $countones($past(mask_reg)) - 1))
        else $error("sent word not removed from bundle");

endmodule

>>> rtl/ultrasonic_echo_ranging_filter.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranging_filter
// Pipeline: stage 1 (edge and window sum), stage 2 (sum times scale), then the
//   output bundle (change window into bundle), where the first result word becomes valid.
// Throughput: one event word per cycle while s_tready is high; an event that finishes
//   k channels sends k result words on the single output port, one per cycle while m_tready is high.
// Reset: asynchronous, clears all channel state, pulse sums start at 100,
//   registers return to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranging_filter
    import uerf_pkg::*;
#(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // head_level, left_level, right_level, timer_count
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // channel, pulse_ticks, distance_q8, rate_q8
    output logic [0:0]       m_tuser,   // trigger
    output logic             m_tlast,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int K_W = $clog2(CHANNELS + 1);

    // configuration registers
    logic [SCALE_W-1:0] scale_reg;
    logic [COUNT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DIST_SCALE: scale_reg <= cfg_wdata[SCALE_W-1:0];
                REG_MEAS_LIMIT: limit_reg <= cfg_wdata[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // pipeline handshake
    logic      v1_reg;
    logic      v2_reg;
    logic      trig1_reg;
    logic      trig2_reg;
    logic      acc;
    logic      any_done;
    logic      free;
    lane_ctl_t ctl;

    assign ctl.adv2  = v2_reg & free;
    assign ctl.adv1  = v1_reg & (~v2_reg | ctl.adv2);
    assign s_tready  = ~v1_reg | ctl.adv1;
    assign acc       = s_tvalid & s_tready;
    assign ctl.load1 = acc & any_done;

    // echo levels per lane, lanes past the real lines stay low
    logic [CHANNELS-1:0] level;
    logic [CHANNELS-1:0] done_vec;
    lane_res_t           lane_res [CHANNELS];

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        if (c < LINES)
        begin : g_line
            assign level[c] = s_tdata[c];
        end
        else
        begin : g_idle
            assign level[c] = 1'b0;
        end

        uerf_lane #(
            .WINDOW (WINDOW)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .acc   (acc),
            .level (level[c]),
            .now   (s_tdata[LINES +: TICK_W]),
            .scale (scale_reg),
            .done  (done_vec[c]),
            .res   (lane_res[c])
        );
    end

    assign any_done = |done_vec;

    // measurement count and ping trigger
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_sum;
    logic [K_W-1:0]     k;
    logic               trig_s0;

    always_comb
    begin
        k = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            k = k + K_W'(done_vec[c]);
        end
    end

    assign count_sum = count_reg + COUNT_W'(k);
    assign trig_s0   = any_done & (count_sum >= limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.load1)
        begin
            count_reg <= trig_s0 ? '0 : count_sum;
        end
    end

    // stage valids and trigger flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            trig1_reg <= 1'b0;
            trig2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.load1 | (v1_reg & ~ctl.adv1);
            v2_reg <= ctl.adv1 | (v2_reg & ~ctl.adv2);
            if (ctl.load1)
            begin
                trig1_reg <= trig_s0;
            end
            if (ctl.adv1)
            begin
                trig2_reg <= trig1_reg;
            end
        end
    end

    // merge and output
    uerf_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ctl.adv2),
        .trig_in  (trig2_reg),
        .res      (lane_res),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ultrasonic echo ranging filter. Pin-change
// event words go in through a randomly gapped stream driver. A predictor
// keeps its own per-channel pulse and change windows and queues the words
// each event should produce. The monitor checks every output word field by
// field while the output side stalls at random, once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import uerf_pkg::*;

    localparam int RING_LEN   = WINDOW_DEF;
    localparam int TICK_LO    = CHAN_W;
    localparam int DIST_LO    = CHAN_W + TICK_W;
    localparam int RATE_LO    = DIST_LO + DIST_W;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 20;
    localparam int IDLE_LIMIT = 3000;

    // one pin-change event waiting to be sent
    typedef struct {
        logic [LINES-1:0]  levels;
        logic [TICK_W-1:0] stamp;
        int                gap;
    } echo_event_t;

    // one finished-channel result word
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [TICK_W-1:0] ticks;
        logic [DIST_W-1:0] dist_q8;
        logic [RATE_W-1:0] rate;
        logic              trig;
        logic              last;
    } range_word_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;     // head_level, left_level, right_level, timer_count
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;          // channel, pulse_ticks, distance_q8, rate_q8
    logic [0:0]       m_tuser;          // trigger
    logic             m_tlast;
    logic             cfg_we = 1'b0;
    logic [0:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // predictor state
    logic [SCALE_W-1:0] scale_now;
    logic [COUNT_W-1:0] limit_now;
    logic [LINES-1:0]   line_seen;
    logic [TICK_W-1:0]  rise_stamp [LINES];
    logic [TICK_W-1:0]  width_ring [LINES][RING_LEN];
    logic [19:0]        width_sum  [LINES];
    logic [RATE_W-1:0]  change_ring [LINES][RING_LEN];
    logic [RATE_W-1:0]  change_sum  [LINES];
    logic [DIST_W-1:0]  last_dist  [LINES];
    int                 ring_slot  [LINES];
    logic [COUNT_W-1:0] completions;

    echo_event_t echo_events [$];
    range_word_t pending_ranges [$];
    echo_event_t next_event;
    echo_event_t offered_event;
    logic        have_next = 1'b0;
    logic        event_taken = 1'b0;
    logic        word_taken = 1'b0;
    logic        hold_request = 1'b0;
    logic        failed = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          recv_calm = 0;
    int          send_calm = 0;
    int          idle_cycles = 0;
    logic [LINES-1:0]  gen_levels = '0;
    logic [TICK_W-1:0] gen_clock = '0;

    ultrasonic_echo_ranging_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // wait length for one word, with occasional stretches of no waiting
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = 15;
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // predict the result words of one event and queue them
    task automatic range_event(input logic [LINES-1:0] lv, input logic [TICK_W-1:0] now);
        range_word_t found [$];
        range_word_t r;
        int          slot;
        logic [TICK_W-1:0] width;
        logic [63:0]       prod;
        logic [DIST_W-1:0] dist_sat;
        logic [RATE_W-1:0] delta;
        for (int c = 0; c < LINES; c++)
        begin
            if (lv[c] != line_seen[c])
            begin
                if (line_seen[c])
                begin
                    // falling edge: pulse finished
                    slot  = ring_slot[c];
                    width = now - rise_stamp[c];
                    width_sum[c] = width_sum[c] - 20'(width_ring[c][slot]) + 20'(width);
                    width_ring[c][slot] = width;
                    prod = (64'(width_sum[c]) * 64'(scale_now)) >> FRAC_SH;
                    dist_sat = (prod > 64'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
                    delta = RATE_W'(dist_sat) - RATE_W'(last_dist[c]);
                    change_sum[c] = change_sum[c] - change_ring[c][slot] + delta;
                    change_ring[c][slot] = delta;
                    last_dist[c] = dist_sat;
                    ring_slot[c] = (slot == RING_LEN - 1) ? 0 : slot + 1;
                    completions = completions + 1'b1;
                    r.chan    = CHAN_W'(c);
                    r.ticks   = width;
                    r.dist_q8 = dist_sat;
                    r.rate    = change_sum[c];
                    r.trig    = 1'b0;
                    r.last    = 1'b0;
                    found.push_back(r);
                end
                else
                begin
                    rise_stamp[c] = now;
                end
                line_seen[c] = lv[c];
            end
        end
        // last word of the event carries last and possibly the ping request
        if (found.size() > 0)
        begin
            found[found.size() - 1].last = 1'b1;
            if (completions >= limit_now)
            begin
                completions = '0;
                found[found.size() - 1].trig = 1'b1;
            end
        end
        foreach (found[i])
            pending_ranges.push_back(found[i]);
    endtask

    task automatic add_event(input logic [LINES-1:0] lv, input logic [TICK_W-1:0] stamp);
        echo_event_t e;
        e.levels = lv;
        e.stamp  = stamp;
        e.gap    = draw_wait(send_calm);
        echo_events.push_back(e);
    endtask

    // random events: mostly real edges on random lines, some with no edge at all
    task automatic add_random_events(input int count);
        logic [LINES-1:0] flip;
        for (int i = 0; i < count; i++)
        begin
            flip = ($urandom_range(0, 9) == 0) ? '0 : LINES'($urandom_range(1, 7));
            gen_levels = gen_levels ^ flip;
            if ($urandom_range(0, 7) == 0)
                gen_clock = TICK_W'($urandom_range(0, 65535));
            else
                gen_clock = gen_clock + TICK_W'($urandom_range(0, 4000));
            add_event(gen_levels, gen_clock);
        end
    endtask

    // wait until every event is taken, every result has arrived and the pipe is empty
    task automatic wait_idle();
        while (echo_events.size() > 0 || have_next || s_tvalid || pending_ranges.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == REG_DIST_SCALE)
            scale_now = value[SCALE_W-1:0];
        else
            limit_now = value[COUNT_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // event driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (event_taken || !s_tvalid)
            begin
                event_taken = 1'b0;
                if (!have_next && echo_events.size() > 0)
                begin
                    next_event = echo_events.pop_front();
                    have_next  = 1'b1;
                end
                if (have_next && next_event.gap == 0)
                begin
                    offered_event = next_event;
                    have_next = 1'b0;
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_W'({next_event.stamp, next_event.levels});
                end
                else
                begin
                    if (have_next)
                        next_event.gap--;
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // event acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            range_event(offered_event.levels, offered_event.stamp);
            event_taken = 1'b1;
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (word_taken)
            begin
                word_taken = 1'b0;
                stall_left = draw_wait(recv_calm);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        range_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            word_taken = 1'b1;
            if (pending_ranges.size() == 0)
            begin
                $error("result word with nothing expected: %h", m_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = pending_ranges.pop_front();
                check_field("channel", 32'(want.chan), 32'(m_tdata[CHAN_W-1:0]));
                check_field("pulse_ticks", 32'(want.ticks), 32'(m_tdata[TICK_LO +: TICK_W]));
                check_field("distance_q8", 32'(want.dist_q8),
                            32'(m_tdata[DIST_LO +: DIST_W]));
                check_field("rate_q8", 32'(want.rate), 32'(m_tdata[RATE_LO +: RATE_W]));
                check_field("trigger", 32'(want.trig), 32'(m_tuser[0]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        // predictor state after reset
        scale_now   = SCALE_RESET;
        limit_now   = LIMIT_RESET;
        line_seen   = '0;
        completions = '0;
        for (int c = 0; c < LINES; c++)
        begin
            rise_stamp[c] = '0;
            width_sum[c]  = 20'(SUM_BIAS);
            change_sum[c] = '0;
            last_dist[c]  = '0;
            ring_slot[c]  = 0;
            for (int k = 0; k < RING_LEN; k++)
            begin
                width_ring[c][k]  = '0;
                change_ring[c][k] = '0;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults: no edge, full-range widths, wrap, zero width, mixed edges
        add_event(3'b000, 16'h1234);
        add_event(3'b111, 16'h0000);
        add_event(3'b111, 16'h5555);
        add_event(3'b000, 16'hFFFF);
        add_event(3'b001, 16'hFFFF);
        add_event(3'b000, 16'h0000);
        add_event(3'b010, 16'h8000);
        add_event(3'b000, 16'h8000);
        add_event(3'b101, 16'h0100);
        add_event(3'b110, 16'h0300);
        add_event(3'b011, 16'h0500);
        add_event(3'b000, 16'h0900);
        wait_idle();

        // largest scale: distance saturates, ping on every completing event
        set_reg(REG_DIST_SCALE, 24'hFFFFFF);
        set_reg(REG_MEAS_LIMIT, 24'd1);
        add_event(3'b111, 16'h0000);
        add_event(3'b000, 16'hF000);
        add_event(3'b100, 16'h1000);
        add_event(3'b000, 16'h1001);
        wait_idle();

        // zero scale after saturation: large negative changes, widest count limit
        set_reg(REG_DIST_SCALE, 24'd0);
        set_reg(REG_MEAS_LIMIT, 24'd255);
        add_event(3'b111, 16'h2000);
        add_event(3'b000, 16'h2010);
        add_event(3'b010, 16'hFFF0);
        add_event(3'b000, 16'h0010);
        wait_idle();

        // random part, first with the output held off to fill the pipe
        set_reg(REG_DIST_SCALE, SCALE_RESET);
        set_reg(REG_MEAS_LIMIT, 24'(LIMIT_RESET));
        hold_request = 1'b1;
        add_random_events(80);
        wait_idle();

        set_reg(REG_DIST_SCALE, 24'($urandom_range(0, 24'hFFFFFF)));
        set_reg(REG_MEAS_LIMIT, 24'($urandom_range(1, 255)));
        add_random_events(50);
        wait_idle();

        set_reg(REG_DIST_SCALE, 24'hFFFFFF);
        set_reg(REG_MEAS_LIMIT, 24'd255);
        add_random_events(50);
        wait_idle();

        set_reg(REG_DIST_SCALE, 24'($urandom_range(1000, 300000)));
        set_reg(REG_MEAS_LIMIT, 24'd1);
        add_random_events(50);
        wait_idle();

        if (pending_ranges.size() != 0)
        begin
            $error("%0d result words never arrived", pending_ranges.size());
            failed = 1'b1;
        end
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
rtl/uerf_pkg.sv
rtl/uerf_lane.sv
rtl/uerf_merge.sv
rtl/ultrasonic_echo_ranging_filter.sv
dv/tb.sv
